// ===== src/alr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_pkg - shared types and constants of the antialiased line rasterizer
// fixed-point formats, item structs, sequencer states and derived widths
// ----------------------------------------------------------------------------
package alr_pkg;

    // coordinate and gradient formats
    localparam int COORD_INT_BITS  = 10;
    localparam int COORD_FRAC_BITS = 6;
    localparam int SLOPE_FRAC_BITS = 16;

    // fixed field widths of the items
    localparam int IN_W = 16;
    localparam int PXW  = 11;
    localparam int AW   = 8;

    // derived widths
    localparam int CW        = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int MJW       = COORD_INT_BITS + 1;
    localparam int SLW       = SLOPE_FRAC_BITS + 2;
    localparam int QUOT_W    = SLOPE_FRAC_BITS + 1;
    localparam int DIV_NUM_W = CW + SLOPE_FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(QUOT_W + 1);
    localparam int MF        = SLOPE_FRAC_BITS + COORD_FRAC_BITS;
    localparam int OFSW      = COORD_FRAC_BITS + 1;
    localparam int GAPW      = COORD_FRAC_BITS + 1;
    localparam int AG_W      = AW + GAPW;
    localparam int ALP_P_W   = AG_W + MF + 1;
    localparam int ALPHA_SHIFT = MF + COORD_FRAC_BITS;
    localparam int MINW_A    = CW + SLOPE_FRAC_BITS + 2;
    localparam int MINW_B    = MF + PXW + 1;
    localparam int MINW      = (MINW_A > MINW_B) ? MINW_A : MINW_B;
    localparam int MUL_A_W   = (SLW > AG_W + 1) ? SLW : AG_W + 1;
    localparam int MUL_B_W   = MF + 2;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int PXE_W     = (MJW > PXW) ? MJW : PXW;

    // constants
    localparam logic [AW-1:0]                ALPHA_RESET = AW'(255);
    localparam logic [COORD_FRAC_BITS-1:0]   HALF_F      =
        COORD_FRAC_BITS'(1 << (COORD_FRAC_BITS - 1));
    localparam logic [GAPW-1:0]              GAP_FULL    = GAPW'(1 << COORD_FRAC_BITS);
    localparam logic [MF:0]                  ONE_M       = (MF + 1)'(1) << MF;
    localparam logic signed [SLW-1:0]        SLOPE_ONE   = SLW'(1) << SLOPE_FRAC_BITS;
    localparam logic [ALP_P_W:0]             ALPHA_ROUND = (ALP_P_W + 1)'(1) << (ALPHA_SHIFT - 1);

    // action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef struct packed {
        logic            action;
        logic [IN_W-1:0] start_x;
        logic [IN_W-1:0] start_y;
        logic [IN_W-1:0] end_x;
        logic [IN_W-1:0] end_y;
    } alr_item_t;

    typedef struct packed {
        logic [PXW-1:0] upper_px_x;
        logic [PXW-1:0] upper_px_y;
        logic [AW-1:0]  upper_alpha;
        logic [PXW-1:0] lower_px_x;
        logic [PXW-1:0] lower_px_y;
        logic [AW-1:0]  lower_alpha;
        logic           last_column;
    } alr_pixel_t;

    typedef enum logic [1:0] {
        PH_FIRST    = 2'd0,
        PH_INTERIOR = 2'd1,
        PH_LAST     = 2'd2
    } alr_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWAP,
        ST_ORDER,
        ST_DIVGO,
        ST_DIV,
        ST_OFS,
        ST_YEND,
        ST_AG,
        ST_UP,
        ST_LO,
        ST_EMIT
    } alr_state_t;

endpackage

// ===== src/alr_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_divider - iterative restoring divider for the line gradient
// one compare-subtract per cycle, one quotient bit per cycle
// ----------------------------------------------------------------------------
module alr_divider
    import alr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] numer,
    input  logic [CW-1:0]        denom,
    output logic                 busy,
    output logic                 done,
    output logic [QUOT_W-1:0]    quot
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]        rem_reg, rem_next;
    logic [CW-1:0]        den_reg, den_next;
    logic [QUOT_W-1:0]    low_reg, low_next;

    logic [CW:0] trial;
    logic [CW:0] diff;
    logic        ge;

    // quotient never needs more than QUOT_W bits, so the top part starts as remainder
    assign trial = {rem_reg, low_reg[QUOT_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(QUOT_W);
            rem_next  = {1'b0, numer[DIV_NUM_W-1:QUOT_W]};
            den_next  = denom;
            low_next  = numer[QUOT_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[CW-1:0] : trial[CW-1:0];
            low_next = {low_reg[QUOT_W-2:0], ge};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        low_reg <= low_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = low_reg;

    // partial remainder stays below the divisor through the whole run
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> (rem_reg < den_reg))
        else $error("divider remainder reached divisor");

    // a new division only begins once the previous one has finished
    assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

// ===== src/alr_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_mul - shared signed multiplier with registered product
// used in turn for the endpoint offset and the alpha scaling
// ----------------------------------------------------------------------------
module alr_mul
    import alr_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output logic signed [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg, prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== src/antialiased_line_rasterizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_unit - antialiased line rasterizer, one column per item
// start items set up a line, step items return one weighted pixel pair each
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  item      in         item_valid / item_stall      alr_item_t  (action, endpoints)
//  pixel     out        pixel_valid / pixel_stall    alr_pixel_t (pixel pair, alphas)
//  cfg       in         cfg_we                       cfg_wdata   (line alpha)
//
//  a start item runs through the accepting cycle, swap, order, divider launch,
//  then one compare-subtract iteration per quotient bit and the done cycle; the
//  division is skipped when both endpoints share one major coordinate
//  a step item runs offset, endpoint minor, alpha gap, upper, lower and emit on an
//  endpoint column and skips the first two on an interior one, sharing one multiplier
//  item_stall is high from acceptance until the sequencer is back in idle
//  the pixel output register frees the sequencer from the consumer: only a
//  second pair finding the register still stalled holds the sequencer
//  reset clears the sequencer, the line and the output valid; alpha returns to 255
//
module antialiased_line_rasterizer_unit
    import alr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  alr_item_t     item,
    output logic          pixel_valid,
    input  logic          pixel_stall,
    output alr_pixel_t    pixel,
    input  logic          cfg_we,
    input  logic [AW-1:0] cfg_wdata
);

    // control state
    alr_state_t state_reg, state_next;
    alr_phase_t phase_reg, phase_next;
    logic       line_active_reg, line_active_next;
    logic       pixel_valid_reg, pixel_valid_next;
    logic [AW-1:0] line_alpha_reg, line_alpha_next;

    // line geometry
    alr_item_t                item_reg, item_next;
    logic                     steep_reg, steep_next;
    logic [CW-1:0]            x0_reg, x0_next;
    logic [CW-1:0]            y0_reg, y0_next;
    logic [CW-1:0]            x1_reg, x1_next;
    logic [CW-1:0]            y1_reg, y1_next;
    logic [CW-1:0]            dx_reg, dx_next;
    logic [CW-1:0]            dyabs_reg, dyabs_next;
    logic                     dyneg_reg, dyneg_next;
    logic [MJW-1:0]           major_pos_reg, major_pos_next;
    logic [MJW-1:0]           major_last_reg, major_last_next;
    logic signed [SLW-1:0]    slope_reg, slope_next;
    logic signed [MINW-1:0]   minor_reg, minor_next;

    // alpha pipeline
    logic [AG_W-1:0]          ag_reg, ag_next;
    logic [ALP_P_W-1:0]       up_prod_reg, up_prod_next;
    alr_pixel_t               pixel_reg, pixel_next;

    // shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic                      div_start;
    logic                      div_busy;
    logic                      div_done;
    logic [QUOT_W-1:0]         div_quot;

    // handshake
    logic item_accept;
    logic emit_fire;

    // start-up datapath
    logic [CW-1:0] in_x0, in_y0, in_x1, in_y1;
    logic [CW-1:0] adx, ady;
    logic          in_steep;
    logic          ord_swap;
    logic [CW-1:0] ox0, oy0, ox1, oy1;
    logic signed [CW:0] ody;
    logic [CW:0]   ox0_half, ox1_half;
    logic signed [SLW-1:0] quot_s;

    // column datapath
    logic                     is_last;
    logic [CW-1:0]            ex, ey;
    logic [MJW-1:0]           emaj;
    logic signed [CW+1:0]     ofs_wide;
    logic signed [OFSW-1:0]   ofs;
    logic [COORD_FRAC_BITS-1:0] xfrac;
    logic [GAPW-1:0]          gap;
    logic [MF-1:0]            fr;
    logic [MF:0]              rf;
    logic [PXW-1:0]           px_major, px_upper, px_lower;
    logic [ALP_P_W:0]         up_sum, lo_sum;
    logic                     next_is_last;

    alr_mul u_mul
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    alr_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer ({dyabs_reg, {SLOPE_FRAC_BITS{1'b0}}}),
        .denom (dx_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign item_stall  = (state_reg != ST_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign emit_fire   = (state_reg == ST_EMIT) && (!pixel_valid_reg || !pixel_stall);

    // steep test on the raw endpoints
    assign in_x0    = CW'(item_reg.start_x);
    assign in_y0    = CW'(item_reg.start_y);
    assign in_x1    = CW'(item_reg.end_x);
    assign in_y1    = CW'(item_reg.end_y);
    assign adx      = (in_x1 > in_x0) ? in_x1 - in_x0 : in_x0 - in_x1;
    assign ady      = (in_y1 > in_y0) ? in_y1 - in_y0 : in_y0 - in_y1;
    assign in_steep = ady > adx;

    // order along the major axis
    assign ord_swap = x0_reg > x1_reg;
    assign ox0      = ord_swap ? x1_reg : x0_reg;
    assign oy0      = ord_swap ? y1_reg : y0_reg;
    assign ox1      = ord_swap ? x0_reg : x1_reg;
    assign oy1      = ord_swap ? y0_reg : y1_reg;
    assign ody      = $signed({1'b0, oy1}) - $signed({1'b0, oy0});
    assign ox0_half = {1'b0, ox0} + (CW + 1)'(HALF_F);
    assign ox1_half = {1'b0, ox1} + (CW + 1)'(HALF_F);
    assign quot_s   = $signed({1'b0, div_quot});

    // endpoint column terms
    assign is_last  = (phase_reg == PH_LAST);
    assign ex       = is_last ? x1_reg : x0_reg;
    assign ey       = is_last ? y1_reg : y0_reg;
    assign emaj     = is_last ? major_last_reg : major_pos_reg;
    assign ofs_wide = $signed({1'b0, emaj, {COORD_FRAC_BITS{1'b0}}}) - $signed({2'b00, ex});
    assign ofs      = ofs_wide[OFSW-1:0];
    assign xfrac    = ex[COORD_FRAC_BITS-1:0] + HALF_F;

    // coverage split of the minor coordinate
    assign fr       = minor_reg[MF-1:0];
    assign rf       = ONE_M - {1'b0, fr};
    assign px_major = PXW'(PXE_W'(emaj));
    assign px_upper = minor_reg[MF +: PXW];
    assign px_lower = px_upper + PXW'(1);
    assign up_sum   = {1'b0, up_prod_reg} + ALPHA_ROUND;
    assign lo_sum   = (ALP_P_W + 1)'(mul_p[ALP_P_W-1:0]) + ALPHA_ROUND;
    assign next_is_last = (major_pos_reg + MJW'(1)) >= major_last_reg;

    always_comb
    begin
        unique case (phase_reg)
            PH_FIRST:    gap = GAP_FULL - GAPW'(xfrac);
            PH_LAST:     gap = GAPW'(xfrac);
            default:     gap = GAP_FULL;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        line_active_next = line_active_reg;
        line_alpha_next  = cfg_we ? cfg_wdata : line_alpha_reg;
        pixel_valid_next = pixel_valid_reg && pixel_stall;
        item_next        = item_reg;
        steep_next       = steep_reg;
        x0_next          = x0_reg;
        y0_next          = y0_reg;
        x1_next          = x1_reg;
        y1_next          = y1_reg;
        dx_next          = dx_reg;
        dyabs_next       = dyabs_reg;
        dyneg_next       = dyneg_reg;
        major_pos_next   = major_pos_reg;
        major_last_next  = major_last_reg;
        slope_next       = slope_reg;
        minor_next       = minor_reg;
        ag_next          = ag_reg;
        up_prod_next     = up_prod_reg;
        pixel_next       = pixel_reg;
        mul_a            = '0;
        mul_b            = '0;
        div_start        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    item_next = item;
                    if (item.action == ACT_START)
                        state_next = ST_SWAP;
                    else if (line_active_reg)
                        state_next = (phase_reg == PH_INTERIOR) ? ST_AG : ST_OFS;
                end
            end
            ST_SWAP:
            begin
                // a start drops any line in progress
                line_active_next = 1'b0;
                steep_next = in_steep;
                x0_next    = in_steep ? in_y0 : in_x0;
                y0_next    = in_steep ? in_x0 : in_y0;
                x1_next    = in_steep ? in_y1 : in_x1;
                y1_next    = in_steep ? in_x1 : in_y1;
                state_next = ST_ORDER;
            end
            ST_ORDER:
            begin
                x0_next         = ox0;
                y0_next         = oy0;
                x1_next         = ox1;
                y1_next         = oy1;
                dx_next         = ox1 - ox0;
                dyneg_next      = ody[CW];
                dyabs_next      = ody[CW] ? CW'(-ody) : CW'(ody);
                major_pos_next  = ox0_half[CW:COORD_FRAC_BITS];
                major_last_next = ox1_half[CW:COORD_FRAC_BITS];
                state_next      = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                if (dx_reg == '0)
                begin
                    // vertical in major terms: gradient of exactly one
                    slope_next       = SLOPE_ONE;
                    phase_next       = PH_FIRST;
                    line_active_next = 1'b1;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    slope_next       = dyneg_reg ? -quot_s : quot_s;
                    phase_next       = PH_FIRST;
                    line_active_next = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_OFS:
            begin
                // slope times distance from the endpoint to its column center
                mul_a      = MUL_A_W'(slope_reg);
                mul_b      = MUL_B_W'(ofs);
                state_next = ST_YEND;
            end
            ST_YEND:
            begin
                minor_next = $signed(MINW'({ey, {SLOPE_FRAC_BITS{1'b0}}})) + MINW'(mul_p);
                state_next = ST_AG;
            end
            ST_AG:
            begin
                mul_a      = MUL_A_W'(line_alpha_reg);
                mul_b      = MUL_B_W'(gap);
                state_next = ST_UP;
            end
            ST_UP:
            begin
                ag_next    = mul_p[AG_W-1:0];
                mul_a      = MUL_A_W'(mul_p[AG_W-1:0]);
                mul_b      = MUL_B_W'(rf);
                state_next = ST_LO;
            end
            ST_LO:
            begin
                up_prod_next = mul_p[ALP_P_W-1:0];
                mul_a        = MUL_A_W'(ag_reg);
                mul_b        = MUL_B_W'(fr);
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold the operands so the product stays while waiting
                mul_a = MUL_A_W'(ag_reg);
                mul_b = MUL_B_W'(fr);
                if (emit_fire)
                begin
                    pixel_valid_next       = 1'b1;
                    pixel_next.upper_px_x  = steep_reg ? px_upper : px_major;
                    pixel_next.upper_px_y  = steep_reg ? px_major : px_upper;
                    pixel_next.upper_alpha = up_sum[ALPHA_SHIFT +: AW];
                    pixel_next.lower_px_x  = steep_reg ? px_lower : px_major;
                    pixel_next.lower_px_y  = steep_reg ? px_major : px_lower;
                    pixel_next.lower_alpha = lo_sum[ALPHA_SHIFT +: AW];
                    pixel_next.last_column = is_last;
                    state_next             = ST_IDLE;
                    if (is_last)
                    begin
                        line_active_next = 1'b0;
                        phase_next       = PH_FIRST;
                    end
                    else
                    begin
                        minor_next     = minor_reg + (MINW'(slope_reg) <<< COORD_FRAC_BITS);
                        major_pos_next = major_pos_reg + MJW'(1);
                        phase_next     = next_is_last ? PH_LAST : PH_INTERIOR;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_FIRST;
            line_active_reg <= 1'b0;
            pixel_valid_reg <= 1'b0;
            line_alpha_reg  <= ALPHA_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            line_active_reg <= line_active_next;
            pixel_valid_reg <= pixel_valid_next;
            line_alpha_reg  <= line_alpha_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        steep_reg      <= steep_next;
        x0_reg         <= x0_next;
        y0_reg         <= y0_next;
        x1_reg         <= x1_next;
        y1_reg         <= y1_next;
        dx_reg         <= dx_next;
        dyabs_reg      <= dyabs_next;
        dyneg_reg      <= dyneg_next;
        major_pos_reg  <= major_pos_next;
        major_last_reg <= major_last_next;
        slope_reg      <= slope_next;
        minor_reg      <= minor_next;
        ag_reg         <= ag_next;
        up_prod_reg    <= up_prod_next;
        pixel_reg      <= pixel_next;
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel       = pixel_reg;

    // a new pixel pair only appears out of the emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pixel_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("pixel pair appeared outside emit");

    // column work only runs on an active line
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OFS || state_reg == ST_YEND || state_reg == ST_AG ||
         state_reg == ST_UP || state_reg == ST_LO || state_reg == ST_EMIT)
        |-> line_active_reg)
        else $error("column step without an active line");

    // gradient of a set-up line never exceeds one in magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        (line_active_reg && state_reg == ST_IDLE)
        |-> (slope_reg <= SLOPE_ONE && slope_reg >= -SLOPE_ONE))
        else $error("gradient out of range");

    // the last column closes the line
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && is_last) |=> !line_active_reg)
        else $error("line still active after its last column");

    // the divider only runs while the sequencer waits for the gradient
    assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == ST_DIV))
        else $error("divider running outside the gradient wait");

endmodule
